### rtl/rv64ex_pkg.sv
`timescale 1ns / 1ps
package rv64ex_pkg;

  localparam int unsigned XLEN      = 64;
  localparam int unsigned DIV_STEPS = 64;

  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_OP32   = 7'h3b;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_JAL    = 7'h6f;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_OPIMM32 = 7'h1b;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;

  typedef enum logic [4:0] {
    OP_UNDEF, OP_ADD, OP_SUB, OP_MUL, OP_SLL, OP_MULH, OP_SLT, OP_XOR, OP_DIV,
    OP_SRL, OP_SRA, OP_OR, OP_REM, OP_AND, OP_ADDW, OP_SUBW, OP_MULW, OP_SLLW,
    OP_DIVW, OP_SRLW, OP_SRAW, OP_DIVUW, OP_REMW, OP_REMUW, OP_PASS, OP_JALR
  } op_e;

  typedef enum logic [2:0] {BR_NONE, BR_EQ, BR_NE, BR_LT, BR_GE} br_e;

  typedef enum logic [1:0] {KIND_SIMPLE, KIND_MUL, KIND_DIV} kind_e;

  typedef struct packed {
    kind_e             kind;
    logic              is_w;
    logic              rem;
    logic              neg;
    logic              dz;
    logic [XLEN-1:0]   res;
    logic [XLEN-1:0]   store;
    logic              taken;
    logic [XLEN-1:0]   npc;
  } side_t;

  typedef struct packed {
    side_t           side;
    logic [XLEN-1:0] mul_a;
    logic [XLEN-1:0] mul_b;
    logic [XLEN-1:0] dvd;
    logic [XLEN-1:0] dvs;
  } s0_t;

  function automatic logic [XLEN-1:0] sx32(input logic [XLEN-1:0] x);
    return {{(XLEN-32){x[31]}}, x[31:0]};
  endfunction

endpackage

### rtl/rv64ex_decode.sv
`timescale 1ns / 1ps
module rv64ex_decode import rv64ex_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            valid_i,
  input  logic [XLEN-1:0] pc_value_i,
  input  logic [XLEN-1:0] operand_a_i,
  input  logic [XLEN-1:0] operand_b_i,
  input  logic [XLEN-1:0] immediate_i,
  input  logic [31:0]     instr_word_i,
  output logic            valid_o,
  output s0_t             s0_o
);

  logic [6:0]      opc;
  logic [2:0]      f3;
  logic [6:0]      f7;
  logic [5:0]      f6;
  op_e             op;
  br_e             br;
  logic            sel_a_pc;
  logic            sel_b_imm;
  logic [XLEN-1:0] a;
  logic [XLEN-1:0] b;
  logic [XLEN-1:0] sum;
  logic [XLEN-1:0] dif;
  logic [XLEN-1:0] res;
  logic            taken;
  logic            slt_ab;
  logic            slt_rr;
  logic [XLEN-1:0] dvd_raw;
  logic [XLEN-1:0] dvs_raw;
  logic            sgn;
  logic            na;
  logic            nb;
  s0_t             s0_d;
  s0_t             s0_q;
  logic            valid_q;

  assign opc = instr_word_i[6:0];
  assign f3  = instr_word_i[14:12];
  assign f7  = instr_word_i[31:25];
  assign f6  = instr_word_i[31:26];

  always_comb begin
    op        = OP_UNDEF;
    br        = BR_NONE;
    sel_a_pc  = 1'b0;
    sel_b_imm = 1'b1;
    unique case (opc)
      OPC_OP: begin
        sel_b_imm = 1'b0;
        if (f7 == 7'h00) begin
          unique case (f3)
            3'd0: op = OP_ADD;
            3'd1: op = OP_SLL;
            3'd2: op = OP_SLT;
            3'd4: op = OP_XOR;
            3'd5: op = OP_SRL;
            3'd6: op = OP_OR;
            3'd7: op = OP_AND;
            default: op = OP_UNDEF;
          endcase
        end else if (f7 == 7'h01) begin
          unique case (f3)
            3'd0: op = OP_MUL;
            3'd1: op = OP_MULH;
            3'd4: op = OP_DIV;
            3'd6: op = OP_REM;
            default: op = OP_UNDEF;
          endcase
        end else if (f7 == 7'h20) begin
          if (f3 == 3'd0) op = OP_SUB;
          else if (f3 == 3'd5) op = OP_SRA;
        end
      end
      OPC_OP32: begin
        sel_b_imm = 1'b0;
        if (f7 == 7'h00) begin
          if (f3 == 3'd0) op = OP_ADDW;
          else if (f3 == 3'd1) op = OP_SLLW;
          else if (f3 == 3'd5) op = OP_SRLW;
        end else if (f7 == 7'h01) begin
          unique case (f3)
            3'd0: op = OP_MULW;
            3'd4: op = OP_DIVW;
            3'd5: op = OP_DIVUW;
            3'd6: op = OP_REMW;
            3'd7: op = OP_REMUW;
            default: op = OP_UNDEF;
          endcase
        end else if (f7 == 7'h20) begin
          if (f3 == 3'd0) op = OP_SUBW;
          else if (f3 == 3'd5) op = OP_SRAW;
        end
      end
      OPC_LOAD, OPC_STORE: begin
        op = (f3 <= 3'd3) ? OP_ADD : OP_UNDEF;
      end
      OPC_OPIMM: begin
        unique case (f3)
          3'd0: op = OP_ADD;
          3'd1: op = (f6 == 6'h00) ? OP_SLL : OP_UNDEF;
          3'd2: op = OP_SLT;
          3'd4: op = OP_XOR;
          3'd5: op = (f6 == 6'h00) ? OP_SRL : ((f6 == 6'h10) ? OP_SRA : OP_UNDEF);
          3'd6: op = OP_OR;
          3'd7: op = OP_AND;
          default: op = OP_UNDEF;
        endcase
      end
      OPC_OPIMM32: begin
        if (f3 == 3'd0) op = OP_ADDW;
        else if (f3 == 3'd1 && f7 == 7'h00) op = OP_SLLW;
        else if (f3 == 3'd5 && f7 == 7'h00) op = OP_SRLW;
        else if (f3 == 3'd5 && f7 == 7'h20) op = OP_SRAW;
      end
      OPC_JALR: begin
        op = (f3 == 3'd0) ? OP_JALR : OP_UNDEF;
      end
      OPC_BRANCH: begin
        sel_a_pc = 1'b1;
        unique case (f3)
          3'd0: begin op = OP_ADD; br = BR_EQ; end
          3'd1: begin op = OP_ADD; br = BR_NE; end
          3'd4: begin op = OP_ADD; br = BR_LT; end
          3'd5: begin op = OP_ADD; br = BR_GE; end
          default: op = OP_UNDEF;
        endcase
      end
      OPC_AUIPC, OPC_JAL: begin
        sel_a_pc = 1'b1;
        op       = OP_ADD;
      end
      OPC_LUI: begin
        sel_a_pc = 1'b1;
        op       = OP_PASS;
      end
      default: op = OP_UNDEF;
    endcase
  end

  assign a      = sel_a_pc ? pc_value_i : operand_a_i;
  assign b      = sel_b_imm ? immediate_i : operand_b_i;
  assign sum    = a + b;
  assign dif    = a - b;
  assign slt_ab = $signed(a) < $signed(b);
  assign slt_rr = $signed(operand_a_i) < $signed(operand_b_i);

  always_comb begin
    unique case (br)
      BR_EQ:   taken = (operand_a_i == operand_b_i);
      BR_NE:   taken = (operand_a_i != operand_b_i);
      BR_LT:   taken = slt_rr;
      BR_GE:   taken = !slt_rr;
      default: taken = 1'b0;
    endcase
  end

  always_comb begin
    unique case (op)
      OP_ADD:  res = sum;
      OP_SUB:  res = dif;
      OP_SLL:  res = a << b[5:0];
      OP_SLT:  res = {{(XLEN-1){1'b0}}, slt_ab};
      OP_XOR:  res = a ^ b;
      OP_SRL:  res = a >> b[5:0];
      OP_SRA:  res = $unsigned($signed(a) >>> b[5:0]);
      OP_OR:   res = a | b;
      OP_AND:  res = a & b;
      OP_ADDW: res = sx32(sum);
      OP_SUBW: res = sx32(dif);
      OP_SLLW: res = sx32(a << b[4:0]);
      OP_SRLW: res = sx32({32'd0, a[31:0] >> b[4:0]});
      OP_SRAW: res = sx32({32'd0, $unsigned($signed(a[31:0]) >>> b[4:0])});
      OP_PASS: res = b;
      OP_JALR: res = {sum[XLEN-1:1], 1'b0};
      default: res = '0;
    endcase
  end

  always_comb begin
    sgn     = 1'b1;
    dvd_raw = a;
    dvs_raw = b;
    unique case (op)
      OP_DIVW, OP_REMW: begin
        dvd_raw = sx32(a);
        dvs_raw = sx32(b);
      end
      OP_DIVUW, OP_REMUW: begin
        sgn     = 1'b0;
        dvd_raw = {32'd0, a[31:0]};
        dvs_raw = {32'd0, b[31:0]};
      end
      default: ;
    endcase
  end

  assign na = sgn & dvd_raw[XLEN-1];
  assign nb = sgn & dvs_raw[XLEN-1];

  always_comb begin
    s0_d            = '0;
    s0_d.mul_a      = a;
    s0_d.mul_b      = b;
    s0_d.dvd        = na ? (~dvd_raw + 1'b1) : dvd_raw;
    s0_d.dvs        = nb ? (~dvs_raw + 1'b1) : dvs_raw;
    s0_d.side.store = operand_b_i;
    s0_d.side.taken = taken;
    s0_d.side.res   = res;
    s0_d.side.rem   = (op == OP_REM) || (op == OP_REMW) || (op == OP_REMUW);
    s0_d.side.neg   = s0_d.side.rem ? na : (na ^ nb);
    s0_d.side.dz    = (dvs_raw == '0);
    s0_d.side.is_w  = (op == OP_MULW) || (op == OP_DIVW) || (op == OP_REMW) ||
                      (op == OP_DIVUW) || (op == OP_REMUW);
    if (op == OP_MUL || op == OP_MULW) begin
      s0_d.side.kind = KIND_MUL;
    end else if (op == OP_DIV || op == OP_REM || op == OP_DIVW || op == OP_REMW ||
                 op == OP_DIVUW || op == OP_REMUW) begin
      s0_d.side.kind = KIND_DIV;
    end else begin
      s0_d.side.kind = KIND_SIMPLE;
    end
    if (opc == OPC_JALR || opc == OPC_JAL || (opc == OPC_BRANCH && taken)) begin
      s0_d.side.npc = res;
    end else begin
      s0_d.side.npc = pc_value_i + 64'd4;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s0_q <= s0_d;
    end
  end

  assign valid_o = valid_q;
  assign s0_o    = s0_q;

endmodule

### rtl/rv64ex_mul.sv
`timescale 1ns / 1ps
module rv64ex_mul import rv64ex_pkg::*; (
  input  logic            clk_i,
  input  logic            adv_i,
  input  logic [XLEN-1:0] a_i,
  input  logic [XLEN-1:0] b_i,
  output logic [XLEN-1:0] prod_o
);

  logic [63:0]     ll_d;
  logic [63:0]     ll_q;
  logic [31:0]     lh_d;
  logic [31:0]     lh_q;
  logic [31:0]     hl_d;
  logic [31:0]     hl_q;
  logic [XLEN-1:0] prod_d;
  logic [XLEN-1:0] prod_q;
  logic [31:0]     mid_sum;

  assign ll_d = 64'(a_i[31:0]) * 64'(b_i[31:0]);
  assign lh_d = a_i[31:0] * b_i[63:32];
  assign hl_d = a_i[63:32] * b_i[31:0];

  assign mid_sum = lh_q + hl_q;
  assign prod_d  = ll_q + {mid_sum, 32'd0};

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ll_q   <= ll_d;
      lh_q   <= lh_d;
      hl_q   <= hl_d;
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

### rtl/rv64ex_div.sv
`timescale 1ns / 1ps
module rv64ex_div import rv64ex_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            valid_i,
  input  s0_t             s0_i,
  input  logic [XLEN-1:0] mul_i,
  output logic            valid_o,
  output side_t           side_o,
  output logic [XLEN-1:0] quot_o,
  output logic [XLEN-1:0] rem_o
);

  logic            v_q    [DIV_STEPS];
  side_t           side_q [DIV_STEPS];
  logic [XLEN-1:0] q_q    [DIV_STEPS];
  logic [XLEN-1:0] r_q    [DIV_STEPS];
  logic [XLEN-1:0] d_q    [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic            v_in;
    side_t           side_in;
    logic [XLEN-1:0] q_in;
    logic [XLEN-1:0] r_in;
    logic [XLEN-1:0] d_in;
    logic [XLEN:0]   rs;
    logic [XLEN:0]   diff;
    logic            ge;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign side_in = s0_i.side;
      assign q_in    = s0_i.dvd;
      assign r_in    = '0;
      assign d_in    = s0_i.dvs;
    end else if (k == 2) begin : g_mul
      always_comb begin
        side_in = side_q[k-1];
        if (side_q[k-1].kind == KIND_MUL) begin
          side_in.res = side_q[k-1].is_w ? sx32(mul_i) : mul_i;
        end
      end
      assign v_in = v_q[k-1];
      assign q_in = q_q[k-1];
      assign r_in = r_q[k-1];
      assign d_in = d_q[k-1];
    end else begin : g_mid
      assign v_in    = v_q[k-1];
      assign side_in = side_q[k-1];
      assign q_in    = q_q[k-1];
      assign r_in    = r_q[k-1];
      assign d_in    = d_q[k-1];
    end

    assign rs   = {r_in, q_in[XLEN-1]};
    assign diff = rs - {1'b0, d_in};
    assign ge   = !diff[XLEN];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (adv_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        side_q[k] <= side_in;
        d_q[k]    <= d_in;
        q_q[k]    <= {q_in[XLEN-2:0], ge};
        r_q[k]    <= ge ? diff[XLEN-1:0] : rs[XLEN-1:0];
      end
    end
  end

  assign valid_o = v_q[DIV_STEPS-1];
  assign side_o  = side_q[DIV_STEPS-1];
  assign quot_o  = q_q[DIV_STEPS-1];
  assign rem_o   = r_q[DIV_STEPS-1];

endmodule

### rtl/rv64_execute_stage.sv
`timescale 1ns / 1ps
// rv64 execute stage
// input channel: valid_i / stall_o with pc_value_i, operand_a_i, operand_b_i,
//   immediate_i and instr_word_i; one transaction is one instruction
// output channel: valid_o / stall_i with alu_result_o, store_data_o,
//   branch_taken_o and next_pc_o; exactly one result per instruction, in order
// path: from accept to valid_o every instruction passes through the decode
//   register, the 64 restoring divider steps (one quotient bit each) and the
//   output register; multiply finishes inside the same pipeline
// throughput: one instruction per cycle, any mix of operations, while not stalled
// stall: while valid_o is high and stall_i is high the whole pipeline holds
//   and stall_o is high; a held result does not change; bubbles move on
//   normally whenever the output register is empty or being taken
// reset: rst_ni clears all valid bits at once; the pipeline is empty and ready
//   as soon as reset is released
module rv64_execute_stage import rv64ex_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            stall_o,
  input  logic [XLEN-1:0] pc_value_i,
  input  logic [XLEN-1:0] operand_a_i,
  input  logic [XLEN-1:0] operand_b_i,
  input  logic [XLEN-1:0] immediate_i,
  input  logic [31:0]     instr_word_i,
  output logic            valid_o,
  input  logic            stall_i,
  output logic [XLEN-1:0] alu_result_o,
  output logic [XLEN-1:0] store_data_o,
  output logic            branch_taken_o,
  output logic [XLEN-1:0] next_pc_o
);

  logic            adv;
  logic            s0_valid;
  s0_t             s0;
  logic [XLEN-1:0] prod;
  logic            dv_valid;
  side_t           dv_side;
  logic [XLEN-1:0] dv_quot;
  logic [XLEN-1:0] dv_rem;
  logic [XLEN-1:0] mag;
  logic [XLEN-1:0] sres;
  logic [XLEN-1:0] res_d;
  logic            out_valid_q;
  logic [XLEN-1:0] res_q;
  logic [XLEN-1:0] store_q;
  logic            taken_q;
  logic [XLEN-1:0] npc_q;

  assign adv     = !(out_valid_q && stall_i);
  assign stall_o = !adv;

  rv64ex_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .valid_i      (valid_i),
    .pc_value_i   (pc_value_i),
    .operand_a_i  (operand_a_i),
    .operand_b_i  (operand_b_i),
    .immediate_i  (immediate_i),
    .instr_word_i (instr_word_i),
    .valid_o      (s0_valid),
    .s0_o         (s0)
  );

  rv64ex_mul u_mul (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .a_i    (s0.mul_a),
    .b_i    (s0.mul_b),
    .prod_o (prod)
  );

  rv64ex_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (s0_valid),
    .s0_i    (s0),
    .mul_i   (prod),
    .valid_o (dv_valid),
    .side_o  (dv_side),
    .quot_o  (dv_quot),
    .rem_o   (dv_rem)
  );

  assign mag  = dv_side.rem ? dv_rem : dv_quot;
  assign sres = (dv_side.dz && !dv_side.rem) ? '1 :
                (dv_side.neg ? (~mag + 1'b1) : mag);

  always_comb begin
    unique case (dv_side.kind)
      KIND_DIV: res_d = dv_side.is_w ? sx32(sres) : sres;
      default:  res_d = dv_side.res;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q   <= res_d;
      store_q <= dv_side.store;
      taken_q <= dv_side.taken;
      npc_q   <= dv_side.npc;
    end
  end

  assign valid_o        = out_valid_q;
  assign alu_result_o   = res_q;
  assign store_data_o   = store_q;
  assign branch_taken_o = taken_q;
  assign next_pc_o      = npc_q;

endmodule

### rtl/rv64ex_checker.sv
`timescale 1ns / 1ps
module rv64ex_checker import rv64ex_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            stall_o,
  input logic            valid_o,
  input logic            stall_i,
  input logic            branch_taken_o,
  input logic [XLEN-1:0] alu_result_o,
  input logic [XLEN-1:0] next_pc_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(alu_result_o) && $stable(next_pc_o))
    else $error("held result changed");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o == (valid_o && stall_i))
    else $error("input stall without a held result");

  a_taken_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && branch_taken_o |-> next_pc_o == alu_result_o)
    else $error("taken branch target mismatch");

endmodule

bind rv64_execute_stage rv64ex_checker u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .stall_o        (stall_o),
  .valid_o        (valid_o),
  .stall_i        (stall_i),
  .branch_taken_o (branch_taken_o),
  .alu_result_o   (alu_result_o),
  .next_pc_o      (next_pc_o)
);
